### rtl/core/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types and constants for the transpose cache directory.
// ----------------------------------------------------------------------------
package tcd_pkg;

   localparam int KEY_W    = 27;
   localparam int PAY_W    = 32;
   localparam int ENTRY_W  = KEY_W + PAY_W;
   localparam int CAP_W    = 10;
   localparam int CNT_W    = 32;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 10'd500;

   // request command codes
   localparam logic [1:0] CMD_LOOKUP     = 2'd0;
   localparam logic [1:0] CMD_INVALIDATE = 2'd1;
   localparam logic [1:0] CMD_CLEAR      = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_SWAP_RD,
      ST_SWAP_WR_LO,
      ST_SWAP_WR_HI,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_MISS_PREP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_INSERT,
      ST_DONE
   } tcd_state_type;

   typedef enum logic [1:0] {
      ADDR_IDX,
      ADDR_PREV,
      ADDR_NEXT
   } addr_sel_type;

   typedef enum logic [1:0] {
      WDATA_RDATA,
      WDATA_HOLD,
      WDATA_NEW
   } wdata_sel_type;

   // controller to datapath
   typedef struct packed {
      logic          load;
      logic          rd_en;
      addr_sel_type  rd_sel;
      logic          wr_en;
      addr_sel_type  wr_sel;
      wdata_sel_type wdata_sel;
      logic          idx_inc;
      logic          idx_dec;
      logic          capture_hit;
      logic          miss_prep;
      logic          occ_dec;
      logic          insert;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] command;
      logic       scan_end;
      logic       del_end;
      logic       idx_zero;
      logic       match;
   } dp_status_type;

endpackage

### rtl/core/transpose_cache_directory.sv
// ----------------------------------------------------------------------------
// transpose_cache_directory
// Ordered key cache with transpose on hit and insert at front on miss.
//
//   channel   ports                      transfer
//   request   start, busy, req_*         start high while busy low
//   response  rsp_strobe, rsp_*          one cycle with rsp_strobe high
//   config    csr_write_enable, csr_*    every edge with enable high and reset low
//
// An entry is scanned through the single registered read port of the entry
// memory, in a read state and then a compare state. A clear goes from decode
// to the strobe; a delete shifts later entries down, a hit at position p > 0
// swaps with its predecessor, and a miss does a full scan plus a full shift.
// The memory needs no clearing pass: reset zeroes occupancy, not the memory.
// The response cannot be held off; busy drops in the cycle after the strobe.
// ----------------------------------------------------------------------------
module transpose_cache_directory #(
   parameter int MAX_ENTRIES = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_command,
   input  logic [2:0]                req_table_number,
   input  logic [23:0]               req_record_index,
   input  logic [31:0]               req_fill_payload,
   output logic                      rsp_strobe,
   output logic                      rsp_hit,
   output logic [31:0]               rsp_payload_out,
   output logic [31:0]               rsp_request_total,
   output logic [31:0]               rsp_hit_total,
   input  logic                      csr_write_enable,
   input  logic [tcd_pkg::CAP_W-1:0] csr_write_data
);
   import tcd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer
   tcd_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // storage and arithmetic
   tcd_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_command       (req_command),
      .req_table_number  (req_table_number),
      .req_record_index  (req_record_index),
      .req_fill_payload  (req_fill_payload),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_hit           (rsp_hit),
      .rsp_payload_out   (rsp_payload_out),
      .rsp_request_total (rsp_request_total),
      .rsp_hit_total     (rsp_hit_total)
   );

endmodule

### rtl/core/tcd_datapath.sv
// ----------------------------------------------------------------------------
// tcd_datapath
// Entry memory, scan pointer, occupancy, counters and result registers.
// ----------------------------------------------------------------------------
module tcd_datapath #(
   parameter int MAX_ENTRIES = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_command,
   input  logic [2:0]                        req_table_number,
   input  logic [23:0]                       req_record_index,
   input  logic [31:0]                       req_fill_payload,
   input  logic                              csr_write_enable,
   input  logic [tcd_pkg::CAP_W-1:0]         csr_write_data,
   input  tcd_pkg::dp_cmd_type               cmd,
   output tcd_pkg::dp_status_type            status,
   output logic                              rsp_hit,
   output logic [31:0]                       rsp_payload_out,
   output logic [31:0]                       rsp_request_total,
   output logic [31:0]                       rsp_hit_total
);
   import tcd_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int OW = $clog2(MAX_ENTRIES + 1);

   logic [ENTRY_W-1:0] entry_mem [MAX_ENTRIES];

   logic [1:0]         command_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [PAY_W-1:0]   fill_ff;
   logic [OW-1:0]      idx_ff, idx_in;
   logic [OW-1:0]      occ_ff, occ_in;
   logic [CNT_W-1:0]   req_cnt_ff, req_cnt_in;
   logic [CNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [CAP_W-1:0]   cap_ff;
   logic [ENTRY_W-1:0] hold_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               hit_ff, hit_in;
   logic [PAY_W-1:0]   payload_ff, payload_in;

   logic [OW-1:0]      idx_prev, idx_next;
   logic [OW-1:0]      eff_cap, occ_adj;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   assign idx_prev = idx_ff - OW'(1);
   assign idx_next = idx_ff + OW'(1);

   // address and write data selection
   always_comb begin
      unique case (cmd.rd_sel)
         ADDR_PREV: rd_addr = idx_prev[AW-1:0];
         ADDR_NEXT: rd_addr = idx_next[AW-1:0];
         default:   rd_addr = idx_ff[AW-1:0];
      endcase
      unique case (cmd.wr_sel)
         ADDR_PREV: wr_addr = idx_prev[AW-1:0];
         ADDR_NEXT: wr_addr = idx_next[AW-1:0];
         default:   wr_addr = idx_ff[AW-1:0];
      endcase
      unique case (cmd.wdata_sel)
         WDATA_HOLD: wr_data = hold_ff;
         WDATA_NEW:  wr_data = {key_ff, fill_ff};
         default:    wr_data = rd_data_ff;
      endcase
   end

   // entry memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   // capacity clamp and occupancy before a miss insert
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = OW'(1);
      end else if (32'(cap_ff) > 32'(MAX_ENTRIES)) begin
         eff_cap = OW'(MAX_ENTRIES);
      end else begin
         eff_cap = OW'(cap_ff);
      end
      occ_adj = occ_ff;
      if (occ_ff >= eff_cap && occ_ff != '0) begin
         occ_adj = occ_ff - OW'(1);
      end
      if (32'(occ_adj) >= 32'(MAX_ENTRIES)) begin
         occ_adj = OW'(MAX_ENTRIES - 1);
      end
   end

   // next values of pointer, occupancy, counters and result
   always_comb begin
      idx_in     = idx_ff;
      occ_in     = occ_ff;
      req_cnt_in = req_cnt_ff;
      hit_cnt_in = hit_cnt_ff;
      hit_in     = hit_ff;
      payload_in = payload_ff;
      if (cmd.load) begin
         idx_in     = '0;
         hit_in     = 1'b0;
         payload_in = '0;
         if (req_command == CMD_LOOKUP) begin
            req_cnt_in = req_cnt_ff + CNT_W'(1);
         end else if (req_command == CMD_CLEAR) begin
            occ_in     = '0;
            req_cnt_in = '0;
            hit_cnt_in = '0;
         end
      end
      if (cmd.idx_inc) begin
         idx_in = idx_next;
      end
      if (cmd.idx_dec) begin
         idx_in = idx_prev;
      end
      if (cmd.capture_hit) begin
         hit_in = 1'b1;
         if (command_ff == CMD_LOOKUP) begin
            hit_cnt_in = hit_cnt_ff + CNT_W'(1);
            payload_in = rd_data_ff[PAY_W-1:0];
         end
      end
      if (cmd.miss_prep) begin
         occ_in = occ_adj;
         idx_in = occ_adj;
      end
      if (cmd.occ_dec) begin
         occ_in = occ_ff - OW'(1);
      end
      if (cmd.insert) begin
         occ_in     = occ_ff + OW'(1);
         payload_in = fill_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         occ_ff     <= '0;
         req_cnt_ff <= '0;
         hit_cnt_ff <= '0;
         cap_ff     <= CAPACITY_RESET;
         hit_ff     <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         occ_ff     <= occ_in;
         req_cnt_ff <= req_cnt_in;
         hit_cnt_ff <= hit_cnt_in;
         hit_ff     <= hit_in;
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
      end
   end

   // request and payload registers
   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      if (cmd.load) begin
         command_ff <= req_command;
         key_ff     <= {req_table_number, req_record_index};
         fill_ff    <= req_fill_payload;
      end
      if (cmd.capture_hit) begin
         hold_ff <= rd_data_ff;
      end
   end

   // status back to the controller
   assign status.command  = command_ff;
   assign status.scan_end = idx_ff >= occ_ff;
   assign status.del_end  = idx_next >= occ_ff;
   assign status.idx_zero = idx_ff == '0;
   assign status.match    = rd_data_ff[ENTRY_W-1:PAY_W] == key_ff;

   assign rsp_hit           = hit_ff;
   assign rsp_payload_out   = payload_ff;
   assign rsp_request_total = req_cnt_ff;
   assign rsp_hit_total     = hit_cnt_ff;

endmodule

### rtl/core/tcd_controller.sv
// ----------------------------------------------------------------------------
// tcd_controller
// Sequencer for scan, transpose, delete-shift and insert-shift.
// ----------------------------------------------------------------------------
module tcd_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  tcd_pkg::dp_status_type status,
   output tcd_pkg::dp_cmd_type    cmd,
   output logic                   busy,
   output logic                   rsp_strobe
);
   import tcd_pkg::*;

   tcd_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.command == CMD_LOOKUP || status.command == CMD_INVALIDATE) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN_RD: begin
            if (status.scan_end) begin
               state_in = (status.command == CMD_LOOKUP) ? ST_MISS_PREP : ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_IDX;
               state_in   = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (status.match) begin
               cmd.capture_hit = 1'b1;
               if (status.command != CMD_LOOKUP) begin
                  state_in = ST_DEL_RD;
               end else if (status.idx_zero) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SWAP_RD;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SCAN_RD;
            end
         end
         ST_SWAP_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ADDR_PREV;
            state_in   = ST_SWAP_WR_LO;
         end
         ST_SWAP_WR_LO: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = ADDR_IDX;
            cmd.wdata_sel = WDATA_RDATA;
            state_in      = ST_SWAP_WR_HI;
         end
         ST_SWAP_WR_HI: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = ADDR_PREV;
            cmd.wdata_sel = WDATA_HOLD;
            state_in      = ST_DONE;
         end
         ST_DEL_RD: begin
            if (status.del_end) begin
               cmd.occ_dec = 1'b1;
               state_in    = ST_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_NEXT;
               state_in   = ST_DEL_WR;
            end
         end
         ST_DEL_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = ADDR_IDX;
            cmd.wdata_sel = WDATA_RDATA;
            cmd.idx_inc   = 1'b1;
            state_in      = ST_DEL_RD;
         end
         ST_MISS_PREP: begin
            cmd.miss_prep = 1'b1;
            state_in      = ST_SHIFT_RD;
         end
         ST_SHIFT_RD: begin
            if (status.idx_zero) begin
               state_in = ST_INSERT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ADDR_PREV;
               state_in   = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = ADDR_IDX;
            cmd.wdata_sel = WDATA_RDATA;
            cmd.idx_dec   = 1'b1;
            state_in      = ST_SHIFT_RD;
         end
         ST_INSERT: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = ADDR_IDX;
            cmd.wdata_sel = WDATA_NEW;
            cmd.insert    = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = state_ff == ST_DONE;

endmodule
